### rtl/grid_point_id_mapper_core_defines.svh
// assertion macros for the grid point id mapper checker
`ifndef GRID_POINT_ID_MAPPER_CORE_DEFINES_SVH
`define GRID_POINT_ID_MAPPER_CORE_DEFINES_SVH

// checked outside reset
`define GPIM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define GPIM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/gpim_pkg.sv
// shared types, constants and helpers of the grid point id mapper
package gpim_pkg;

  localparam int MAX_DIM_DEF    = 16;
  localparam int MAX_POINTS_DEF = 4096;

  localparam int SIZE_W     = 5;
  localparam int SIZE_LIMIT = (1 << SIZE_W) - 1;
  localparam int COORD_W    = 4;
  localparam int BASE_W     = 32;
  localparam int ID_W       = 33;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MULT_W     = 10;

  localparam logic [MULT_W-1:0] SHUFFLE_MULT = 10'd833;

  typedef enum logic {
    CMD_BUILD  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_UNBUILT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X         = 3'd0,
    REG_SIZE_Y         = 3'd1,
    REG_SIZE_Z         = 3'd2,
    REG_MORTON_ENABLE  = 3'd3,
    REG_SHUFFLE_ENABLE = 3'd4,
    REG_NODE_BASE      = 3'd5,
    REG_ELEMENT_BASE   = 3'd6
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic walk;
    logic build_done;
    logic lin;
    logic chk;
    logic mul;
    logic mod_step;
    logic res_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;
    logic mod_last;
    logic shuffle;
  } dp_stat_t;

  // zero acts as one, anything above the dimension limit acts as the limit
  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] raw, int max_dim);
    logic [SIZE_W-1:0] r;
    r = raw;
    if (raw == '0) begin
      r = SIZE_W'(1);
    end else if (int'(raw) > max_dim) begin
      r = SIZE_W'(max_dim);
    end
    return r;
  endfunction

endpackage

### rtl/gpim_ifs.sv
// request, response and configuration channel interfaces
interface gpim_req_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [gpim_pkg::COORD_W-1:0]   coord_i;
  logic [gpim_pkg::COORD_W-1:0]   coord_j;
  logic [gpim_pkg::COORD_W-1:0]   coord_k;

  modport source (output valid, cmd, coord_i, coord_j, coord_k, input ready);
  modport sink (input valid, cmd, coord_i, coord_j, coord_k, output ready);
endinterface

interface gpim_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gpim_pkg::ID_W-1:0]     node_ident;
  logic [gpim_pkg::ID_W-1:0]     element_ident;
  logic [gpim_pkg::STAT_W-1:0]   status;

  modport source (output valid, node_ident, element_ident, status, input ready);
  modport sink (input valid, node_ident, element_ident, status, output ready);
endinterface

interface gpim_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gpim_pkg::CFG_IDX_W-1:0]   index;
  logic [gpim_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/gpim_datapath.sv
// datapath: config registers, rank table, index arithmetic and modulo unit
module gpim_datapath #(
  parameter int MAX_DIM    = gpim_pkg::MAX_DIM_DEF,
  parameter int MAX_POINTS = gpim_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gpim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpim_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gpim_pkg::cmd_t                      op,
  input  logic [gpim_pkg::COORD_W-1:0]        coord_i,
  input  logic [gpim_pkg::COORD_W-1:0]        coord_j,
  input  logic [gpim_pkg::COORD_W-1:0]        coord_k,
  input  gpim_pkg::ctrl_t                     ctrl,
  output gpim_pkg::dp_stat_t                  stat,
  output logic [gpim_pkg::ID_W-1:0]           node_ident,
  output logic [gpim_pkg::ID_W-1:0]           element_ident,
  output logic [gpim_pkg::STAT_W-1:0]         status
);

  localparam int SIZE_W   = gpim_pkg::SIZE_W;
  localparam int COORD_W  = gpim_pkg::COORD_W;
  localparam int BASE_W   = gpim_pkg::BASE_W;
  localparam int ID_W     = gpim_pkg::ID_W;
  localparam int DIM_BITS = $clog2(MAX_DIM);
  localparam int CODE_W   = 3 * DIM_BITS;
  localparam int EFF_DIM  = (MAX_DIM < gpim_pkg::SIZE_LIMIT) ? MAX_DIM : gpim_pkg::SIZE_LIMIT;
  localparam int NPTS_MAX = EFF_DIM * EFF_DIM * EFF_DIM;
  localparam int IDX_W    = $clog2(NPTS_MAX);
  localparam int NPTS_W   = $clog2(NPTS_MAX + 1);
  localparam int R_W      = NPTS_W + 1;
  localparam int PW       = IDX_W + gpim_pkg::MULT_W;
  localparam int MC_W     = $clog2(PW);
  localparam int TBL_AW   = $clog2(MAX_POINTS);
  localparam int AX_W     = (IDX_W > TBL_AW) ? IDX_W : TBL_AW;
  localparam int CMP_W    = (DIM_BITS > SIZE_W) ? DIM_BITS : SIZE_W;
  localparam int SYZ_W    = 2 * SIZE_W;
  localparam logic [31:0] MAXP = 32'(MAX_POINTS);

  // configuration
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic              morton_en, shuffle_en;
  logic [BASE_W-1:0] node_base, element_base;
  logic              built;

  logic [SIZE_W-1:0] sx_e, sy_e, sz_e;

  // request registers
  gpim_pkg::cmd_t     op_r;
  logic [COORD_W-1:0] ci_r, cj_r, ck_r;
  logic [SYZ_W-1:0]   syz;

  // table walk
  logic [CODE_W-1:0]   code;
  logic [IDX_W-1:0]    rank;
  logic [DIM_BITS-1:0] wci, wcj, wck;
  logic                in_grid;
  logic [IDX_W-1:0]    walk_lin;
  logic [AX_W-1:0]     walk_ax;
  logic                walk_store;

  logic [IDX_W-1:0] rank_table [MAX_POINTS];

  // lookup
  logic                in_rng;
  logic                rng_bad;
  logic                bad;
  logic [IDX_W-1:0]    look_lin;
  logic [IDX_W-1:0]    lin_r;
  logic [AX_W-1:0]     look_ax;
  logic [NPTS_W-1:0]   npts;
  logic [IDX_W-1:0]    rd;
  logic [IDX_W-1:0]    idx_sel;
  logic [IDX_W-1:0]    idx_r;
  logic [PW-1:0]       prod;
  logic [R_W-1:0]      rem;
  logic [R_W-1:0]      rem_sh;
  logic [MC_W-1:0]     mcnt;
  logic [IDX_W-1:0]    fidx;

  assign sx_e = gpim_pkg::eff_size(size_x, MAX_DIM);
  assign sy_e = gpim_pkg::eff_size(size_y, MAX_DIM);
  assign sz_e = gpim_pkg::eff_size(size_z, MAX_DIM);

  // morton code split into axis coordinates
  always_comb begin
    for (int b = 0; b < DIM_BITS; b++) begin
      wci[b] = code[3*b];
      wcj[b] = code[3*b+1];
      wck[b] = code[3*b+2];
    end
  end

  assign in_grid = (CMP_W'(wci) < CMP_W'(sx_e)) && (CMP_W'(wcj) < CMP_W'(sy_e)) &&
                   (CMP_W'(wck) < CMP_W'(sz_e));
  assign walk_lin = IDX_W'(wci) * IDX_W'(syz) + IDX_W'(wcj) * IDX_W'(sz_e) + IDX_W'(wck);
  assign walk_ax = AX_W'(walk_lin);
  assign walk_store = ctrl.walk && in_grid && (32'(walk_lin) < MAXP);

  assign in_rng = (SIZE_W'(ci_r) < sx_e) && (SIZE_W'(cj_r) < sy_e) && (SIZE_W'(ck_r) < sz_e);
  assign look_lin = IDX_W'(ci_r) * IDX_W'(syz) + IDX_W'(cj_r) * IDX_W'(sz_e) + IDX_W'(ck_r);
  assign look_ax = AX_W'(lin_r);

  assign idx_sel = morton_en ? rd : lin_r;
  assign rem_sh = {rem[R_W-2:0], prod[PW-1]};
  assign fidx = shuffle_en ? rem[IDX_W-1:0] : idx_r;

  assign stat.walk_last = &code;
  assign stat.mod_last = (mcnt == '0);
  assign stat.shuffle = shuffle_en;

  // config registers and build flag
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x       <= SIZE_W'(1);
      size_y       <= SIZE_W'(1);
      size_z       <= SIZE_W'(1);
      morton_en    <= 1'b0;
      shuffle_en   <= 1'b0;
      node_base    <= '0;
      element_base <= '0;
      built        <= 1'b0;
    end else begin
      if (ctrl.build_done) begin
        built <= 1'b1;
      end
      if (cfg_we) begin
        unique case (gpim_pkg::cfg_reg_t'(cfg_index))
          gpim_pkg::REG_SIZE_X: begin
            size_x <= cfg_data[SIZE_W-1:0];
            built  <= 1'b0;
          end
          gpim_pkg::REG_SIZE_Y: begin
            size_y <= cfg_data[SIZE_W-1:0];
            built  <= 1'b0;
          end
          gpim_pkg::REG_SIZE_Z: begin
            size_z <= cfg_data[SIZE_W-1:0];
            built  <= 1'b0;
          end
          gpim_pkg::REG_MORTON_ENABLE:  morton_en <= cfg_data[0];
          gpim_pkg::REG_SHUFFLE_ENABLE: shuffle_en <= cfg_data[0];
          gpim_pkg::REG_NODE_BASE:      node_base <= cfg_data[BASE_W-1:0];
          gpim_pkg::REG_ELEMENT_BASE:   element_base <= cfg_data[BASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // rank table
  always_ff @(posedge clk) begin
    if (walk_store) begin
      rank_table[walk_ax[TBL_AW-1:0]] <= rank;
    end
    if (ctrl.chk) begin
      rd <= rank_table[look_ax[TBL_AW-1:0]];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      op_r <= op;
      ci_r <= coord_i;
      cj_r <= coord_j;
      ck_r <= coord_k;
      syz  <= SYZ_W'(sy_e) * SYZ_W'(sz_e);
      code <= '0;
      rank <= '0;
    end
    if (ctrl.walk) begin
      code <= code + CODE_W'(1);
      rank <= rank + IDX_W'(in_grid);
    end
    if (ctrl.lin) begin
      lin_r   <= look_lin;
      npts    <= NPTS_W'(sx_e) * NPTS_W'(syz);
      rng_bad <= !in_rng;
    end
    if (ctrl.chk) begin
      bad <= rng_bad || (32'(lin_r) >= MAXP);
    end
    if (ctrl.mul) begin
      idx_r <= idx_sel;
      prod  <= PW'(idx_sel) * PW'(gpim_pkg::SHUFFLE_MULT);
      rem   <= '0;
      mcnt  <= MC_W'(PW - 1);
    end
    if (ctrl.mod_step) begin
      rem  <= (rem_sh >= R_W'(npts)) ? rem_sh - R_W'(npts) : rem_sh;
      prod <= prod << 1;
      mcnt <= mcnt - MC_W'(1);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      if (op_r == gpim_pkg::CMD_BUILD) begin
        node_ident    <= '0;
        element_ident <= '0;
        status        <= gpim_pkg::STAT_OK;
      end else if (bad) begin
        node_ident    <= '0;
        element_ident <= '0;
        status        <= gpim_pkg::STAT_RANGE;
      end else if (morton_en && !built) begin
        node_ident    <= '0;
        element_ident <= '0;
        status        <= gpim_pkg::STAT_UNBUILT;
      end else begin
        node_ident    <= ID_W'(fidx) + ID_W'(node_base);
        element_ident <= ID_W'(fidx) + ID_W'(element_base);
        status        <= gpim_pkg::STAT_OK;
      end
    end
  end

endmodule

### rtl/gpim_ctrl.sv
// controller: sequences table builds and lookups, owns the response valid
module gpim_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  gpim_pkg::cmd_t     op,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output gpim_pkg::ctrl_t    ctrl,
  input  gpim_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LIN,
    S_CHK,
    S_MUL,
    S_MOD,
    S_DONE
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctrl = '0;
    unique case (state)
      S_IDLE: ctrl.cap = req_valid;
      S_WALK: begin
        ctrl.walk       = 1'b1;
        ctrl.build_done = stat.walk_last;
      end
      S_LIN:  ctrl.lin = 1'b1;
      S_CHK:  ctrl.chk = 1'b1;
      S_MUL:  ctrl.mul = 1'b1;
      S_MOD:  ctrl.mod_step = 1'b1;
      S_DONE: ctrl.res_load = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (ctrl.res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (op == gpim_pkg::CMD_BUILD) ? S_WALK : S_LIN;
          end
        end
        S_WALK: begin
          if (stat.walk_last) begin
            state <= S_DONE;
          end
        end
        S_LIN: state <= S_CHK;
        S_CHK: state <= S_MUL;
        S_MUL: state <= stat.shuffle ? S_MOD : S_DONE;
        S_MOD: begin
          if (stat.mod_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (ctrl.res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/grid_point_id_mapper_core.sv
// top level of the grid point id mapper
// One request at a time. A lookup runs through the LIN, CHK and MUL states to the
// response register and, when shuffle is on, through MOD, which holds the bit-serial
// modulo by the point count. A build (cmd 0) walks every Morton code, one per cycle,
// through the rank table write port. The response register lets the next request be
// accepted while a response waits. Configuration writes are always ready.
module grid_point_id_mapper_core #(
  parameter int MAX_DIM    = gpim_pkg::MAX_DIM_DEF,
  parameter int MAX_POINTS = gpim_pkg::MAX_POINTS_DEF
) (
  input logic      clk,
  input logic      rst,
  gpim_cfg_if.sink cfg,
  gpim_req_if.sink req,
  gpim_rsp_if.source rsp
);

  gpim_pkg::ctrl_t    ctrl;
  gpim_pkg::dp_stat_t stat;

  assign cfg.ready = 1'b1;

  gpim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .op        (gpim_pkg::cmd_t'(req.cmd)),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  gpim_datapath #(
    .MAX_DIM    (MAX_DIM),
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .op            (gpim_pkg::cmd_t'(req.cmd)),
    .coord_i       (req.coord_i),
    .coord_j       (req.coord_j),
    .coord_k       (req.coord_k),
    .ctrl          (ctrl),
    .stat          (stat),
    .node_ident    (rsp.node_ident),
    .element_ident (rsp.element_ident),
    .status        (rsp.status)
  );

endmodule

### rtl/gpim_checker.sv
// port-level checker for the grid point id mapper, bound to the top level
`include "grid_point_id_mapper_core_defines.svh"

module gpim_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [gpim_pkg::ID_W-1:0]     node_ident,
  input logic [gpim_pkg::ID_W-1:0]     element_ident,
  input logic [gpim_pkg::STAT_W-1:0]   status
);

  `GPIM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
  `GPIM_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(node_ident) && $stable(element_ident) && $stable(status), "stalled response changed")
  `GPIM_ASSERT(a_err_zero, rsp_valid && status != gpim_pkg::STAT_OK |-> node_ident == '0 && element_ident == '0, "error response carries nonzero ids")
  `GPIM_ASSERT(a_no_early_rsp, req_valid && req_ready |=> !$rose(rsp_valid), "response right after request")
  `GPIM_ASSERT_ALWAYS(a_rst_clear, rst |=> !rsp_valid, "response valid after reset")

endmodule

bind grid_point_id_mapper_core gpim_checker u_gpim_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .node_ident    (rsp.node_ident),
  .element_ident (rsp.element_ident),
  .status        (rsp.status)
);

### dv/tb.sv
// self-checking testbench of grid_point_id_mapper_core with a built-in id predictor
module tb;

  localparam int SIZE_W         = gpim_pkg::SIZE_W;
  localparam int COORD_W        = gpim_pkg::COORD_W;
  localparam int BASE_W         = gpim_pkg::BASE_W;
  localparam int ID_W           = gpim_pkg::ID_W;
  localparam int CFG_IDX_W      = gpim_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = gpim_pkg::CFG_DATA_W;
  localparam int MAX_DIM        = gpim_pkg::MAX_DIM_DEF;
  localparam int MAX_POINTS     = gpim_pkg::MAX_POINTS_DEF;
  localparam int ZBITS          = $clog2(MAX_DIM);
  localparam int ZCODES         = 1 << (3 * ZBITS);
  localparam int RANDOM_ITEMS   = 1200;
  localparam int WATCHDOG_LIMIT = 16000;
  localparam int SETTLE_CYCLES  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [ID_W-1:0]   node;
    logic [ID_W-1:0]   elem;
    gpim_pkg::status_t st;
  } id_result_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  gpim_cfg_if cfg_ch ();
  gpim_req_if req_ch ();
  gpim_rsp_if rsp_ch ();

  grid_point_id_mapper_core DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state
  logic [SIZE_W-1:0]  dim_raw [3];
  logic               morton_on;
  logic               shuffle_on;
  logic [BASE_W-1:0]  node_base;
  logic [BASE_W-1:0]  elem_base;
  logic               ranks_valid;
  logic [11:0]        zorder_rank [MAX_POINTS];

  id_result_t  id_expect_q [$];
  reg_write_t  pending_writes [$];
  int          mismatches;
  int          items_sent;
  int          quiet_cycles;
  int          rsp_stall;
  bit          idle_gaps;

  always #5 clk = ~clk;

  function automatic int unsigned eff_dim(logic [SIZE_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > MAX_DIM) begin
      return MAX_DIM;
    end
    return raw;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      gpim_pkg::REG_SIZE_X: begin
        dim_raw[0] = data[SIZE_W-1:0];
        ranks_valid = 1'b0;
      end
      gpim_pkg::REG_SIZE_Y: begin
        dim_raw[1] = data[SIZE_W-1:0];
        ranks_valid = 1'b0;
      end
      gpim_pkg::REG_SIZE_Z: begin
        dim_raw[2] = data[SIZE_W-1:0];
        ranks_valid = 1'b0;
      end
      gpim_pkg::REG_MORTON_ENABLE:  morton_on = data[0];
      gpim_pkg::REG_SHUFFLE_ENABLE: shuffle_on = data[0];
      gpim_pkg::REG_NODE_BASE:      node_base = data;
      gpim_pkg::REG_ELEMENT_BASE:   elem_base = data;
      default: ;
    endcase
  endfunction

  // walk z-order codes upward, numbering the points inside the grid
  function automatic void build_zorder_ranks();
    int unsigned ex, ey, ez, code, b, ci, cj, ck, lin, rank;
    ex = eff_dim(dim_raw[0]);
    ey = eff_dim(dim_raw[1]);
    ez = eff_dim(dim_raw[2]);
    rank = 0;
    for (code = 0; code < ZCODES; code++) begin
      ci = 0;
      cj = 0;
      ck = 0;
      for (b = 0; b < ZBITS; b++) begin
        ci |= ((code >> (3 * b)) & 1) << b;
        cj |= ((code >> (3 * b + 1)) & 1) << b;
        ck |= ((code >> (3 * b + 2)) & 1) << b;
      end
      if (ci < ex && cj < ey && ck < ez) begin
        lin = ci * ey * ez + cj * ez + ck;
        if (lin < MAX_POINTS) begin
          zorder_rank[lin] = rank[11:0];
        end
        rank++;
      end
    end
    ranks_valid = 1'b1;
  endfunction

  function automatic void predict_ids(gpim_pkg::cmd_t c, logic [COORD_W-1:0] i,
                                      logic [COORD_W-1:0] j, logic [COORD_W-1:0] k);
    int unsigned ex, ey, ez, npts, idx;
    id_result_t r;
    ex = eff_dim(dim_raw[0]);
    ey = eff_dim(dim_raw[1]);
    ez = eff_dim(dim_raw[2]);
    npts = ex * ey * ez;
    r.node = '0;
    r.elem = '0;
    r.st = gpim_pkg::STAT_OK;
    if (c == gpim_pkg::CMD_BUILD) begin
      build_zorder_ranks();
    end else if (i >= ex || j >= ey || k >= ez) begin
      r.st = gpim_pkg::STAT_RANGE;
    end else begin
      idx = i * ey * ez + j * ez + k;
      if (idx >= MAX_POINTS) begin
        r.st = gpim_pkg::STAT_RANGE;
      end else if (morton_on && !ranks_valid) begin
        r.st = gpim_pkg::STAT_UNBUILT;
      end else begin
        if (morton_on) begin
          idx = zorder_rank[idx];
        end
        if (shuffle_on) begin
          idx = (idx * gpim_pkg::SHUFFLE_MULT) % npts;
        end
        r.node = ID_W'(idx) + ID_W'(node_base);
        r.elem = ID_W'(idx) + ID_W'(elem_base);
      end
    end
    id_expect_q.insert(id_expect_q.size(), r);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_point(gpim_pkg::cmd_t c, logic [COORD_W-1:0] i, logic [COORD_W-1:0] j,
                            logic [COORD_W-1:0] k);
    int gap;
    gap = idle_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= c;
    req_ch.coord_i <= i;
    req_ch.coord_j <= j;
    req_ch.coord_k <= k;
    do @(posedge clk); while (!req_ch.ready);
    predict_ids(c, i, j, k);
    items_sent++;
  endtask

  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (id_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic queue_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    pending_writes.insert(pending_writes.size(), w);
  endtask

  // registers change only with the block idle
  task automatic flush_writes();
    reg_write_t w;
    drain_responses();
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= w.idx;
      cfg_ch.data  <= w.data;
      do @(posedge clk); while (!cfg_ch.ready);
      apply_reg(w.idx, w.data);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic lookup(int i, int j, int k);
    send_point(gpim_pkg::CMD_LOOKUP, COORD_W'(i), COORD_W'(j), COORD_W'(k));
  endtask

  task automatic build_ranks();
    send_point(gpim_pkg::CMD_BUILD, COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom));
  endtask

  task automatic test_reset_state();
    idle_gaps = 0;
    lookup(0, 0, 0);
    lookup(15, 15, 15);
    lookup(0, 0, 1);
  endtask

  task automatic test_linear_index();
    queue_write(gpim_pkg::REG_SIZE_X, 32'd16);
    queue_write(gpim_pkg::REG_SIZE_Y, 32'd16);
    queue_write(gpim_pkg::REG_SIZE_Z, 32'd16);
    queue_write(gpim_pkg::REG_NODE_BASE, 32'hFFFF_FFFF);
    queue_write(gpim_pkg::REG_ELEMENT_BASE, 32'd0);
    queue_write(REG_UNUSED, 32'hFFFF_FFFF);
    flush_writes();
    lookup(15, 15, 15);
    lookup(0, 0, 0);
    lookup(5, 10, 3);
  endtask

  task automatic test_zorder_rank();
    queue_write(gpim_pkg::REG_SIZE_X, 32'd3);
    queue_write(gpim_pkg::REG_SIZE_Y, 32'd5);
    queue_write(gpim_pkg::REG_SIZE_Z, 32'd2);
    queue_write(gpim_pkg::REG_MORTON_ENABLE, 32'd1);
    queue_write(gpim_pkg::REG_NODE_BASE, 32'd100);
    queue_write(gpim_pkg::REG_ELEMENT_BASE, 32'hFFFF_FF00);
    flush_writes();
    lookup(1, 1, 1);
    lookup(3, 0, 0);
    build_ranks();
    lookup(2, 4, 1);
    lookup(1, 2, 0);
    // rewriting a size with the same value still invalidates the table
    queue_write(gpim_pkg::REG_SIZE_Z, 32'd2);
    flush_writes();
    lookup(0, 0, 1);
    build_ranks();
    lookup(2, 3, 1);
  endtask

  task automatic test_shuffle();
    queue_write(gpim_pkg::REG_SIZE_X, 32'd7);
    queue_write(gpim_pkg::REG_SIZE_Y, 32'd1);
    queue_write(gpim_pkg::REG_SIZE_Z, 32'd13);
    queue_write(gpim_pkg::REG_MORTON_ENABLE, 32'd0);
    queue_write(gpim_pkg::REG_SHUFFLE_ENABLE, 32'd1);
    queue_write(gpim_pkg::REG_NODE_BASE, 32'h1234_5678);
    flush_writes();
    lookup(6, 0, 12);
    lookup(3, 0, 5);
    queue_write(gpim_pkg::REG_MORTON_ENABLE, 32'd1);
    flush_writes();
    build_ranks();
    lookup(4, 0, 9);
  endtask

  task automatic test_size_clamping();
    queue_write(gpim_pkg::REG_SIZE_X, 32'd0);
    queue_write(gpim_pkg::REG_SIZE_Y, 32'd31);
    queue_write(gpim_pkg::REG_SIZE_Z, 32'hFFFF_FFE5);
    queue_write(gpim_pkg::REG_MORTON_ENABLE, 32'd0);
    queue_write(gpim_pkg::REG_SHUFFLE_ENABLE, 32'd0);
    flush_writes();
    lookup(0, 15, 4);
    lookup(1, 0, 0);
    lookup(0, 3, 5);
    queue_write(gpim_pkg::REG_SIZE_X, 32'd17);
    flush_writes();
    lookup(15, 15, 4);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size_raw();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom_range(17, 31);
      2: return 32'd16;
      3: return $urandom;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_base();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_traffic();
    int target, n, r;
    bit first;
    target = items_sent + RANDOM_ITEMS;
    first = 1;
    while (items_sent < target) begin
      if (first || $urandom_range(0, 1)) begin
        queue_write(gpim_pkg::REG_SIZE_X, pick_size_raw());
        queue_write(gpim_pkg::REG_SIZE_Y, pick_size_raw());
        queue_write(gpim_pkg::REG_SIZE_Z, pick_size_raw());
      end
      if (first || $urandom_range(0, 1)) queue_write(gpim_pkg::REG_MORTON_ENABLE, $urandom);
      if (first || $urandom_range(0, 1)) queue_write(gpim_pkg::REG_SHUFFLE_ENABLE, $urandom);
      if (first || $urandom_range(0, 1)) queue_write(gpim_pkg::REG_NODE_BASE, pick_base());
      if (first || $urandom_range(0, 1)) queue_write(gpim_pkg::REG_ELEMENT_BASE, pick_base());
      if ($urandom_range(0, 7) == 0) queue_write(REG_UNUSED, $urandom);
      first = 0;
      flush_writes();
      idle_gaps = ($urandom_range(0, 3) != 0);
      if (morton_on && $urandom_range(0, 4) != 0) build_ranks();
      n = $urandom_range(20, 60);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          build_ranks();
        end else if (r < 85) begin
          lookup($urandom_range(0, eff_dim(dim_raw[0]) - 1),
                 $urandom_range(0, eff_dim(dim_raw[1]) - 1),
                 $urandom_range(0, eff_dim(dim_raw[2]) - 1));
        end else begin
          lookup($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
        end
      end
    end
  endtask

  // response check
  always @(posedge clk) begin : rsp_check
    id_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (id_expect_q.size() == 0) begin
        report_mismatch("response with no request pending");
      end else begin
        want = id_expect_q.pop_front();
        if (rsp_ch.status !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.st));
        if (rsp_ch.node_ident !== want.node)
          report_mismatch($sformatf("node_ident %h, want %h", rsp_ch.node_ident, want.node));
        if (rsp_ch.element_ident !== want.elem)
          report_mismatch($sformatf("element_ident %h, want %h", rsp_ch.element_ident,
                                    want.elem));
      end
    end
  end

  // response backpressure
  always @(posedge clk) begin
    if (rsp_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall--;
    end else if (idle_gaps && $urandom_range(0, 99) < 20) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall = pick_gap();
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = gpim_pkg::CMD_BUILD;
    req_ch.coord_i = '0;
    req_ch.coord_j = '0;
    req_ch.coord_k = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    dim_raw[0] = 5'd1;
    dim_raw[1] = 5'd1;
    dim_raw[2] = 5'd1;
    morton_on = 1'b0;
    shuffle_on = 1'b0;
    node_base = '0;
    elem_base = '0;
    ranks_valid = 1'b0;
    mismatches = 0;
    items_sent = 0;
    quiet_cycles = 0;
    rsp_stall = 0;
    idle_gaps = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_linear_index();
    test_zorder_rank();
    test_shuffle();
    test_size_clamping();
    test_random_traffic();

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### grid_point_id_mapper_core.f
+incdir+rtl
rtl/gpim_pkg.sv
rtl/gpim_ifs.sv
rtl/gpim_datapath.sv
rtl/gpim_ctrl.sv
rtl/grid_point_id_mapper_core.sv
rtl/gpim_checker.sv
dv/tb.sv
